[rtl/key_matrix_debounce_antighost_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the key matrix debouncer
// Each macro expands to a concurrent assertion on clk / rst_n in simulation
// and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_ANTIGHOST_TOP_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_ANTIGHOST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KMDAG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define KMDAG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KMDAG_ASSERT_IMP(lbl, ante, cons, msg)
`define KMDAG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/kmdag_pkg.sv]
// ----------------------------------------------------------------------------
// kmdag_pkg
// Shared types and codes of the key matrix debouncer.
// ----------------------------------------------------------------------------
`default_nettype none
package kmdag_pkg;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_DIRECT  = 2'd2;
    localparam logic [1:0] MODE_CONTACT = 2'd3;

    localparam int PIN_SLOTS = 64;

    typedef struct packed {
        logic [1:0]  mode;
        logic        entry_kind;
        logic [2:0]  source;
        logic [5:0]  pin_a;
        logic [5:0]  pin_b;
        logic        level;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [31:0] event_id;
        logic        event_kind;
        logic [2:0]  event_source;
        logic [5:0]  event_pin_a;
        logic [5:0]  event_pin_b;
        logic        down;
    } out_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  src;
        logic [5:0]  pa;
        logic [5:0]  pb;
        logic        raw;
        logic        stable;
        logic        reported;
        logic [31:0] changed;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic clear;
        logic add;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic cap;
        logic reach_init;
        logic grew_clr;
        logic reach_step;
        logic wr_raw;
        logic settle_plain;
        logic settle_emit;
        logic suppress;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       empty;
        logic       match;
        logic       last;
        logic       settle;
        logic       ghost_chk;
        logic       release_quiet;
        logic       reach_pb;
        logic       grew;
    } stat_t;

endpackage
`default_nettype wire

[rtl/kmdag_ctrl.sv]
// ----------------------------------------------------------------------------
// kmdag_ctrl
// Sequencer: table lookup walk, debounce decision, ghost reachability passes.
// ----------------------------------------------------------------------------
`default_nettype none
module kmdag_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  kmdag_pkg::stat_t    st,
    output kmdag_pkg::cmd_t     cmd
);
    import kmdag_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_DECIDE   = 8'b0001_0000,
        S_G_RD     = 8'b0010_0000,
        S_G_CHK    = 8'b0100_0000,
        S_G_END    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (st.mode)
                    MODE_CLEAR: cmd.clear = 1'b1;
                    MODE_ADD:   cmd.add   = !st.full;
                    default:
                    begin
                        if (!st.empty)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (st.match)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (st.last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (!st.settle)
                begin
                    cmd.wr_raw = 1'b1;
                end
                else if (st.ghost_chk)
                begin
                    cmd.reach_init = 1'b1;
                    cmd.grew_clr   = 1'b1;
                    cmd.idx_clr    = 1'b1;
                    state_next     = S_G_RD;
                end
                else if (st.release_quiet)
                begin
                    cmd.settle_plain = 1'b1;
                end
                else
                begin
                    cmd.settle_emit = 1'b1;
                end
            end
            S_G_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_G_CHK;
            end
            S_G_CHK:
            begin
                cmd.reach_step = 1'b1;
                if (st.last)
                begin
                    state_next = S_G_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_G_RD;
                end
            end
            S_G_END:
            begin
                state_next = S_IDLE;
                if (st.reach_pb)
                begin
                    cmd.suppress = 1'b1;
                end
                else if (st.grew)
                begin
                    cmd.grew_clr = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_G_RD;
                end
                else
                begin
                    cmd.settle_emit = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

[rtl/kmdag_dp.sv]
// ----------------------------------------------------------------------------
// kmdag_dp
// Entry table memory, candidate register, reach vector, event output.
// ----------------------------------------------------------------------------
`default_nettype none
module kmdag_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  kmdag_pkg::in_t      item,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data,
    input  kmdag_pkg::cmd_t     cmd,
    output kmdag_pkg::stat_t    st,
    output logic                strobe,
    output kmdag_pkg::out_t     result
);
    import kmdag_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    entry_t                 mem [MAX_ENTRIES];
    in_t                    in_reg;
    logic [CW-1:0]          count_reg;
    logic [31:0]            evnum_reg;
    logic [15:0]            deb_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          cand_idx_reg;
    entry_t                 cand_reg;
    entry_t                 rd_reg;
    logic [PIN_SLOTS-1:0]   reach_reg;
    logic                   grew_reg;
    logic                   strobe_reg;
    out_t                   res_reg;

    entry_t                 add_entry;
    entry_t                 cap_entry;
    entry_t                 wdata;
    logic                   we;
    logic [IW-1:0]          waddr;
    logic                   active;
    logic [31:0]            elapsed;
    logic                   link;
    logic [PIN_SLOTS-1:0]   reach_next;

    // new entry starts released
    always_comb
    begin
        add_entry          = '0;
        add_entry.kind     = in_reg.entry_kind;
        add_entry.src      = in_reg.entry_kind ? in_reg.source : 3'd0;
        add_entry.pa       = in_reg.pin_a;
        add_entry.pb       = in_reg.entry_kind ? in_reg.pin_b : 6'd0;
        add_entry.changed  = in_reg.now_ms;
    end

    // direct pins are active low
    assign active = (in_reg.mode == MODE_DIRECT) ? ~in_reg.level : in_reg.level;

    always_comb
    begin
        cap_entry = rd_reg;
        if (active != rd_reg.raw)
        begin
            cap_entry.raw     = active;
            cap_entry.changed = in_reg.now_ms;
        end
    end

    always_comb
    begin
        wdata = cand_reg;
        waddr = cand_idx_reg;
        we    = cmd.wr_raw | cmd.settle_plain | cmd.settle_emit | cmd.suppress;
        if (cmd.settle_plain)
        begin
            wdata.stable = cand_reg.raw;
        end
        if (cmd.settle_emit)
        begin
            wdata.stable   = cand_reg.raw;
            wdata.reported = cand_reg.raw;
        end
        if (cmd.suppress)
        begin
            wdata.stable   = 1'b1;
            wdata.reported = 1'b0;
        end
        if (cmd.add)
        begin
            wdata = add_entry;
            waddr = count_reg[IW-1:0];
            we    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // one reach step: a reported-down contact of the same source joins its pins
    assign link = (idx_reg != cand_idx_reg) && rd_reg.stable && rd_reg.reported
                  && rd_reg.kind && (rd_reg.src == cand_reg.src)
                  && (reach_reg[rd_reg.pa] || reach_reg[rd_reg.pb]);

    always_comb
    begin
        reach_next = reach_reg;
        if (link)
        begin
            reach_next[rd_reg.pa] = 1'b1;
            reach_next[rd_reg.pb] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= item;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.cap)
        begin
            cand_reg     <= cap_entry;
            cand_idx_reg <= idx_reg;
        end
        if (cmd.reach_init)
        begin
            reach_reg <= PIN_SLOTS'(1) << cand_reg.pa;
        end
        else if (cmd.reach_step)
        begin
            reach_reg <= reach_next;
        end
        if (cmd.grew_clr)
        begin
            grew_reg <= 1'b0;
        end
        else if (cmd.reach_step && (reach_next != reach_reg))
        begin
            grew_reg <= 1'b1;
        end
        if (cmd.settle_emit)
        begin
            res_reg.event_id     <= evnum_reg;
            res_reg.event_kind   <= cand_reg.kind;
            res_reg.event_source <= cand_reg.src;
            res_reg.event_pin_a  <= cand_reg.pa;
            res_reg.event_pin_b  <= cand_reg.pb;
            res_reg.down         <= cand_reg.raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            evnum_reg  <= '0;
            deb_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.settle_emit;
            if (cfg_we)
            begin
                deb_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.add)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.settle_emit)
            begin
                evnum_reg <= evnum_reg + 32'd1;
            end
        end
    end

    assign elapsed = in_reg.now_ms - cand_reg.changed;

    always_comb
    begin
        st.mode          = in_reg.mode;
        st.full          = (count_reg == CW'(MAX_ENTRIES));
        st.empty         = (count_reg == '0);
        st.match         = (in_reg.mode == MODE_DIRECT)
                         ? (!rd_reg.kind && rd_reg.pa == in_reg.pin_a)
                         : (rd_reg.kind && rd_reg.src == in_reg.source
                            && rd_reg.pa == in_reg.pin_a && rd_reg.pb == in_reg.pin_b);
        st.last          = ((CW'(idx_reg) + CW'(1)) == count_reg);
        st.settle        = (cand_reg.raw != cand_reg.stable) && (elapsed >= {16'd0, deb_reg});
        st.ghost_chk     = cand_reg.raw && cand_reg.kind;
        st.release_quiet = !cand_reg.raw && !cand_reg.reported;
        st.reach_pb      = reach_reg[cand_reg.pb];
        st.grew          = grew_reg;
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

[rtl/key_matrix_debounce_antighost_top.sv]
// ----------------------------------------------------------------------------
// key_matrix_debounce_antighost_top
// Debounced direct pins and matrix contacts with ghost-key blocking.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low; the item is taken on that
// edge and busy stays high until the work is done. A clear or add is done in
// the dispatch state. A sample walks the entry table, reading then checking
// each entry until the first match or the table's end; on a match it decides,
// and if a contact closes stably the ghost check runs reachability passes over
// the table until the contact's second pin is reached or no new pin joins (at
// most entries+1 passes). Each event appears on result for exactly one
// cycle with strobe high; the receiver must take it then, as there is no
// backpressure. The user writes debounce_ms through cfg_we/cfg_data while
// busy is low and the last item's event is out; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_matrix_debounce_antighost_top_macros.svh"
module key_matrix_debounce_antighost_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  kmdag_pkg::in_t      item,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data,
    output logic                strobe,
    output kmdag_pkg::out_t     result
);
    import kmdag_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // sequencer
    kmdag_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    // table, candidate, reach vector and event register
    kmdag_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .st       (st),
        .strobe   (strobe),
        .result   (result)
    );

    // an event transfer lasts one cycle
    `KMDAG_ASSERT_NXT(a_strobe_single, strobe, !strobe, "strobe held longer than one cycle")
    // events only come out of work in progress
    `KMDAG_ASSERT_IMP(a_strobe_from_work, strobe, $past(busy), "event without work")
    // an accepted item makes the block busy
    `KMDAG_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item not worked")

endmodule
`default_nettype wire
